### design/u8d_pkg.sv
package u8d_pkg;

  localparam int CAP_BITS   = 20;
  localparam int CP_BITS    = 32;
  localparam int CNT_OUT_W  = 20;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS  = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CAP_BITS-1:0] CAP_RESET = 20'd1023;

  // Register index of the configuration port.
  localparam logic REG_CAPACITY = 1'b0;

  // Lead byte class boundaries and payload masks.
  localparam logic [7:0] LEAD6_MIN  = 8'hfc;
  localparam logic [7:0] LEAD5_MIN  = 8'hf8;
  localparam logic [7:0] LEAD4_MIN  = 8'hf0;
  localparam logic [7:0] LEAD3_MIN  = 8'he0;
  localparam logic [7:0] MULTI_MIN  = 8'h80;
  localparam logic [7:0] MASK_CONT  = 8'h3f;
  localparam logic [7:0] MASK_LEAD6 = 8'h03;
  localparam logic [7:0] MASK_LEAD4 = 8'h07;
  localparam logic [7:0] MASK_LEAD3 = 8'h0f;
  localparam logic [7:0] MASK_LEAD2 = 8'h1f;

  typedef enum logic [1:0] {
    KIND_CODE     = 2'd0,
    KIND_DONE     = 2'd1,
    KIND_OVERFLOW = 2'd2
  } kind_t;

  typedef struct packed {
    logic [CP_BITS-1:0]   code_point;
    kind_t                kind;
    logic [CNT_OUT_W-1:0] char_count;
    logic                 last_result;
  } result_t;

  // Up to two results written into the queue in one cycle, packed from slot a.
  typedef struct packed {
    logic [1:0] num;
    result_t    a;
    result_t    b;
  } push_t;

endpackage

### design/utf8_to_ucs4_decoder.sv
// Channel  | Handshake         | Payload
// in_      | in_valid/in_stall | in_data_byte[7:0], in_end_of_input
// out_     | out_valid/out_stall | out_code_point[31:0], out_kind[1:0],
//          |                   | out_char_count[19:0], out_last_result
// config   | APB (psel..pready)| capacity at byte address 0
//
// A byte is registered at the input, then decoded and written into
// a four-entry result queue. One byte is taken per cycle while the
// input does not stall; a byte that ends a character together with the
// end mark yields two words, and then the single output port sets the
// rate. Input stalls while a byte is held and the queue cannot take two
// more words. Reset clears all string state and sets capacity to 1023.
module utf8_to_ucs4_decoder #(
  parameter int COUNT_BITS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_code_point,
  output logic [1:0]  out_kind,
  output logic [19:0] out_char_count,
  output logic        out_last_result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration.
  logic [u8d_pkg::CAP_BITS-1:0] cap_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= u8d_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && paddr[2] == u8d_pkg::REG_CAPACITY) begin
      cap_r <= pwdata[u8d_pkg::CAP_BITS-1:0];
    end
  end

  assign prdata = (paddr[2] == u8d_pkg::REG_CAPACITY) ? 32'(cap_r) : 32'd0;

  // Input register.
  logic                          stage_vld_r;
  logic [7:0]                    byte_r;
  logic                          eoi_r;
  logic                          stage_fire;
  logic                          in_take;
  logic [u8d_pkg::QCNT_BITS-1:0] q_count;

  assign stage_fire = stage_vld_r && (q_count <= u8d_pkg::QCNT_BITS'(u8d_pkg::QUEUE_DEPTH - 2));
  assign in_stall   = stage_vld_r && !stage_fire;
  assign in_take    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
    end else if (in_take) begin
      stage_vld_r <= 1'b1;
    end else if (stage_fire) begin
      stage_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_r <= in_data_byte;
      eoi_r  <= in_end_of_input;
    end
  end

  // String state.
  logic [2:0]            pend_r,   pend_nxt;
  logic [31:0]           part_r,   part_nxt;
  logic [COUNT_BITS-1:0] cnt_r,    cnt_nxt;
  logic                  closed_r, closed_nxt;

  logic [2:0]            lead_pend;
  logic [31:0]           lead_part;
  logic [2:0]            step_pend;
  logic [31:0]           step_part;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [31:0]           cnt_ext;
  logic [31:0]           cnt_inc_ext;
  logic                  at_limit;
  u8d_pkg::push_t        push;
  u8d_pkg::result_t      code_res;
  u8d_pkg::result_t      done_res;
  u8d_pkg::result_t      done_inc_res;
  u8d_pkg::result_t      ovf_res;

  always_comb begin
    if (byte_r >= u8d_pkg::LEAD6_MIN) begin
      lead_pend = 3'd5;
      lead_part = 32'(byte_r & u8d_pkg::MASK_LEAD6);
    end else if (byte_r >= u8d_pkg::LEAD5_MIN) begin
      lead_pend = 3'd4;
      lead_part = 32'(byte_r & u8d_pkg::MASK_LEAD6);
    end else if (byte_r >= u8d_pkg::LEAD4_MIN) begin
      lead_pend = 3'd3;
      lead_part = 32'(byte_r & u8d_pkg::MASK_LEAD4);
    end else if (byte_r >= u8d_pkg::LEAD3_MIN) begin
      lead_pend = 3'd2;
      lead_part = 32'(byte_r & u8d_pkg::MASK_LEAD3);
    end else if (byte_r < u8d_pkg::MULTI_MIN) begin
      lead_pend = 3'd0;
      lead_part = 32'(byte_r);
    end else begin
      lead_pend = 3'd1;
      lead_part = 32'(byte_r & u8d_pkg::MASK_LEAD2);
    end
  end

  assign step_pend = (pend_r == 3'd0) ? lead_pend : pend_r - 3'd1;
  assign step_part = (pend_r == 3'd0) ? lead_part :
                     {part_r[25:0], byte_r[5:0] & u8d_pkg::MASK_CONT[5:0]};

  assign cnt_inc     = cnt_r + COUNT_BITS'(1);
  assign cnt_ext     = 32'(cnt_r);
  assign cnt_inc_ext = 32'(cnt_inc);
  // The count saturates at its own width as well as at the capacity.
  assign at_limit    = (cnt_ext >= 32'(cap_r)) || (&cnt_r);

  always_comb begin
    code_res             = '0;
    code_res.code_point  = step_part;
    code_res.kind        = u8d_pkg::KIND_CODE;
    done_res             = '0;
    done_res.kind        = u8d_pkg::KIND_DONE;
    done_res.char_count  = cnt_ext[19:0];
    done_res.last_result = 1'b1;
    done_inc_res            = done_res;
    done_inc_res.char_count = cnt_inc_ext[19:0];
    ovf_res              = '0;
    ovf_res.kind         = u8d_pkg::KIND_OVERFLOW;
    ovf_res.last_result  = 1'b1;
  end

  always_comb begin
    pend_nxt   = pend_r;
    part_nxt   = part_r;
    cnt_nxt    = cnt_r;
    closed_nxt = closed_r;
    push       = '0;
    if (stage_fire) begin
      if (closed_r) begin
        if (eoi_r) begin
          pend_nxt   = '0;
          part_nxt   = '0;
          cnt_nxt    = '0;
          closed_nxt = 1'b0;
        end
      end else if (pend_r == 3'd0 && (byte_r == 8'd0 || at_limit)) begin
        push.num = 2'd1;
        push.a   = (byte_r == 8'd0) ? done_res : ovf_res;
        if (eoi_r) begin
          pend_nxt = '0;
          part_nxt = '0;
          cnt_nxt  = '0;
        end else begin
          closed_nxt = 1'b1;
        end
      end else if (step_pend == 3'd0) begin
        push.num = eoi_r ? 2'd2 : 2'd1;
        push.a   = code_res;
        push.b   = done_inc_res;
        pend_nxt = '0;
        part_nxt = '0;
        cnt_nxt  = eoi_r ? '0 : cnt_inc;
      end else if (eoi_r) begin
        // An unfinished sequence at the end of the buffer is dropped.
        push.num = 2'd1;
        push.a   = done_res;
        pend_nxt = '0;
        part_nxt = '0;
        cnt_nxt  = '0;
      end else begin
        pend_nxt = step_pend;
        part_nxt = step_part;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= '0;
      part_r   <= '0;
      cnt_r    <= '0;
      closed_r <= 1'b0;
    end else begin
      pend_r   <= pend_nxt;
      part_r   <= part_nxt;
      cnt_r    <= cnt_nxt;
      closed_r <= closed_nxt;
    end
  end

  // Result queue.
  u8d_pkg::result_t head;
  logic             q_pop;

  assign q_pop = out_valid && !out_stall;

  u8d_res_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (q_pop),
    .head  (head),
    .count (q_count)
  );

  assign out_valid       = (q_count != '0);
  assign out_code_point  = head.code_point;
  assign out_kind        = head.kind;
  assign out_char_count  = head.char_count;
  assign out_last_result = head.last_result;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= u8d_pkg::QCNT_BITS'(u8d_pkg::QUEUE_DEPTH))
    else $error("result queue count beyond its depth");

  a_closed_silent: assert property (@(posedge clk) disable iff (!rst_n)
    closed_r |-> push.num == 2'd0)
    else $error("closed string produced a result");

  a_pair_ends: assert property (@(posedge clk) disable iff (!rst_n)
    push.num == 2'd2 |-> (push.a.kind == u8d_pkg::KIND_CODE &&
                          push.b.kind == u8d_pkg::KIND_DONE && push.b.last_result))
    else $error("two results must be a code point followed by done");

  a_closed_resets: assert property (@(posedge clk) disable iff (!rst_n)
    closed_r |-> pend_r == 3'd0)
    else $error("closed string with a sequence still pending");

endmodule

### design/u8d_res_queue.sv
module u8d_res_queue (
  input  logic                              clk,
  input  logic                              rst_n,
  input  u8d_pkg::push_t                    push,
  input  logic                              pop,
  output u8d_pkg::result_t                  head,
  output logic [u8d_pkg::QCNT_BITS-1:0]     count
);

  u8d_pkg::result_t                 entry_r [u8d_pkg::QUEUE_DEPTH];
  logic [u8d_pkg::QPTR_BITS-1:0]    wr_ptr_r;
  logic [u8d_pkg::QPTR_BITS-1:0]    rd_ptr_r;
  logic [u8d_pkg::QCNT_BITS-1:0]    count_r;
  logic [u8d_pkg::QPTR_BITS-1:0]    wr_ptr_nxt;
  logic [u8d_pkg::QPTR_BITS-1:0]    rd_ptr_nxt;
  logic [u8d_pkg::QCNT_BITS-1:0]    count_nxt;
  logic [u8d_pkg::QPTR_BITS-1:0]    wr_ptr_b;

  assign wr_ptr_b   = wr_ptr_r + u8d_pkg::QPTR_BITS'(1);
  assign wr_ptr_nxt = wr_ptr_r + u8d_pkg::QPTR_BITS'(push.num);
  assign rd_ptr_nxt = rd_ptr_r + u8d_pkg::QPTR_BITS'(pop);
  assign count_nxt  = count_r + u8d_pkg::QCNT_BITS'(push.num) - u8d_pkg::QCNT_BITS'(pop);

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      entry_r[wr_ptr_r] <= push.a;
    end
    if (push.num == 2'd2) begin
      entry_r[wr_ptr_b] <= push.b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign head  = entry_r[rd_ptr_r];
  assign count = count_r;

endmodule
